// ----- hw/rtl/lal_pkg.sv -----
package lal_pkg;

  // reading / calibration level width
  localparam int LVL_W = 10;
  // lux constants and their widths
  localparam int LUX_W  = 8;
  localparam int DLUX_W = 7;
  localparam int ILL_W  = 16;
  // interpolation numerator: level difference times lux span
  localparam int NUM_W  = LVL_W + DLUX_W;

  localparam int RING_SIZE_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_20  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_50  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_100 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_200 = 4'd3;

  localparam logic [LVL_W-1:0] LEVEL_20_RST  = 10'd100;
  localparam logic [LVL_W-1:0] LEVEL_50_RST  = 10'd300;
  localparam logic [LVL_W-1:0] LEVEL_100_RST = 10'd600;
  localparam logic [LVL_W-1:0] LEVEL_200_RST = 10'd900;

  localparam logic [LUX_W-1:0] LUX_0   = 8'd0;
  localparam logic [LUX_W-1:0] LUX_20  = 8'd20;
  localparam logic [LUX_W-1:0] LUX_50  = 8'd50;
  localparam logic [LUX_W-1:0] LUX_100 = 8'd100;
  localparam logic [LUX_W-1:0] LUX_200 = 8'd200;

  localparam logic [ILL_W-1:0] ILL_MAX = 16'hFFFF;

  typedef struct packed {
    logic [LVL_W-1:0] l20;
    logic [LVL_W-1:0] l50;
    logic [LVL_W-1:0] l100;
    logic [LVL_W-1:0] l200;
  } cfg_levels_t;

endpackage

// ----- hw/rtl/lal_front.sv -----
module lal_front #(
  parameter int RING_SIZE = lal_pkg::RING_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [lal_pkg::LVL_W-1:0] in_reading,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [lal_pkg::LVL_W-1:0] push_avg
);

  localparam int LW       = lal_pkg::LVL_W;
  localparam int RING_LOG = $clog2(RING_SIZE);
  localparam int SLOT_W   = (RING_SIZE > 1) ? RING_LOG : 1;
  localparam int SUM_W    = LW + RING_LOG;
  // exact floor(sum / RING_SIZE) as (sum * M) >> S for every SUM_W-bit sum
  localparam int RECIP_S  = SUM_W + RING_LOG;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_S) + 64'(RING_SIZE) - 64'd1) / 64'(RING_SIZE);
  localparam int M_W      = SUM_W + 1;
  localparam logic [M_W-1:0] RECIP_M = RECIP_FULL[M_W-1:0];
  localparam int PROD_W   = SUM_W + M_W;

  typedef enum logic [2:0] {
    F_IDLE   = 3'b001,
    F_SAMPLE = 3'b010,
    F_PUSH   = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [LW-1:0]        ring_mem [RING_SIZE];
  logic [RING_SIZE-1:0] valid_r;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [LW-1:0]        old_rd_r;
  logic                 old_valid_r;
  logic [LW-1:0]        reading_r;
  logic [PROD_W-1:0]    prod_r;
  logic [LW-1:0]        old_val;
  logic                 accept, sample_acc, output_acc;

  assign in_ready   = (state_r == F_IDLE);
  assign accept     = in_valid && in_ready;
  assign sample_acc = accept && !in_kind;
  assign output_acc = accept && in_kind;

  assign push_valid = (state_r == F_PUSH);
  assign push_avg   = prod_r[RECIP_S +: LW];

  // never-written slots read as zero
  assign old_val = old_valid_r ? old_rd_r : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (sample_acc) state_nxt = F_SAMPLE;
        else if (output_acc) state_nxt = F_PUSH;
      end
      F_SAMPLE: state_nxt = F_IDLE;
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    slot_nxt = slot_r;
    if (sample_acc) begin
      if (slot_r == SLOT_W'(RING_SIZE - 1)) slot_nxt = '0;
      else slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (state_r == F_SAMPLE) sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(reading_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
      sum_r   <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      sum_r   <= sum_nxt;
      if (sample_acc) valid_r[slot_r] <= 1'b1;
    end
  end

  // ring memory: read-before-write on the slot being replaced
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      ring_mem[slot_r] <= in_reading;
      old_rd_r         <= ring_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      old_valid_r <= valid_r[slot_r];
      reading_r   <= in_reading;
    end
    if (output_acc) prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP_M);
  end

endmodule

// ----- hw/rtl/lal_queue.sv -----
module lal_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  logic [lal_pkg::LVL_W-1:0] push_data,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output logic [lal_pkg::LVL_W-1:0] pop_data
);

  localparam int DEPTH = lal_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [lal_pkg::LVL_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- hw/rtl/lal_back.sv -----
module lal_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lal_pkg::cfg_levels_t      levels,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  logic [lal_pkg::LVL_W-1:0] pop_avg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lal_pkg::ILL_W-1:0] out_illum
);

  localparam int LW    = lal_pkg::LVL_W;
  localparam int UW    = lal_pkg::LUX_W;
  localparam int DW    = lal_pkg::DLUX_W;
  localparam int NW    = lal_pkg::NUM_W;
  localparam int IW    = lal_pkg::ILL_W;
  localparam int CNT_W = $clog2(NW + 1);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SETUP = 4'b0010,
    B_DIV   = 4'b0100,
    B_FIN   = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [LW-1:0]    avg_r;
  logic [NW-1:0]    dq_r;       // dividend in, quotient out
  logic [LW-1:0]    rem_r;
  logic [LW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, zero_r;
  logic [UW-1:0]    lo_lux_r, hi_lux_r;
  logic             out_valid_r;
  logic [IW-1:0]    out_illum_r;

  // segment selection
  logic [LW-1:0] lo_lvl, hi_lvl;
  logic [UW-1:0] lo_lux, hi_lux;
  logic [LW-1:0] diff;
  logic [LW:0]   seg_w;
  logic [DW-1:0] dlux;
  logic [NW-1:0] num;

  always_comb begin
    if (avg_r <= levels.l20) begin
      lo_lvl = '0;          hi_lvl = levels.l20;
      lo_lux = lal_pkg::LUX_0;   hi_lux = lal_pkg::LUX_20;
    end else if (avg_r <= levels.l50) begin
      lo_lvl = levels.l20;  hi_lvl = levels.l50;
      lo_lux = lal_pkg::LUX_20;  hi_lux = lal_pkg::LUX_50;
    end else if (avg_r <= levels.l100) begin
      lo_lvl = levels.l50;  hi_lvl = levels.l100;
      lo_lux = lal_pkg::LUX_50;  hi_lux = lal_pkg::LUX_100;
    end else begin
      lo_lvl = levels.l100; hi_lvl = levels.l200;
      lo_lux = lal_pkg::LUX_100; hi_lux = lal_pkg::LUX_200;
    end
    // avg is never below the segment's low level, so diff is non-negative
    diff  = avg_r - lo_lvl;
    seg_w = {1'b0, hi_lvl} - {1'b0, lo_lvl};
    dlux  = DW'(hi_lux - lo_lux);
    num   = NW'(diff) * NW'(dlux);
  end

  // restoring divider step
  logic [LW:0]   trial;
  logic          ge;
  logic [LW-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, dq_r[NW-1]};
    ge       = (trial >= {1'b0, den_r});
    rem_step = ge ? LW'(trial - {1'b0, den_r}) : trial[LW-1:0];
  end

  // final: sign, offset, clamp
  logic [NW:0]   pos_sum;
  logic [IW-1:0] result;

  always_comb begin
    pos_sum = {1'b0, dq_r} + (NW + 1)'(lo_lux_r);
    if (zero_r) begin
      result = IW'(hi_lux_r);
    end else if (neg_r) begin
      if (dq_r > NW'(lo_lux_r)) result = '0;
      else result = IW'(lo_lux_r) - dq_r[IW-1:0];
    end else begin
      if (pos_sum > (NW + 1)'(lal_pkg::ILL_MAX)) result = lal_pkg::ILL_MAX;
      else result = pos_sum[IW-1:0];
    end
  end

  logic out_load;
  assign out_load  = (state_r == B_FIN) && (!out_valid_r || out_ready);
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_illum = out_illum_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) state_nxt = B_SETUP;
      end
      B_SETUP: state_nxt = (seg_w == '0) ? B_FIN : B_DIV;
      B_DIV: begin
        if (cnt_r == CNT_W'(1)) state_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop_valid) avg_r <= pop_avg;
      end
      B_SETUP: begin
        dq_r     <= num;
        rem_r    <= '0;
        neg_r    <= seg_w[LW];
        zero_r   <= (seg_w == '0);
        den_r    <= seg_w[LW] ? LW'(-seg_w) : seg_w[LW-1:0];
        lo_lux_r <= lo_lux;
        hi_lux_r <= hi_lux;
        cnt_r    <= CNT_W'(NW);
      end
      B_DIV: begin
        dq_r  <= {dq_r[NW-2:0], ge};
        rem_r <= rem_step;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
    if (out_load) out_illum_r <= result;
  end

endmodule

// ----- hw/rtl/light_average_to_lux_unit.sv -----
// Light-sensor averaging and lux calibration.
// in_*  : stream of items. in_tuser = kind (0 store sample, 1 emit lux),
//         in_tdata[9:0] = converter reading (used for samples only).
// out_* : one transfer per kind-1 item, out_tdata = illuminance in lux.
// cfg_* : register writes (index, 10-bit level), always ready; write only
//         while no item is in flight.
// A sample passes the front end as a ring read, then a sum update.
// For a lux item the front end forms the average with one multiply by a
// reciprocal of the ring size; the back end then takes it through queue
// pop, setup, 17 steps of the bit-serial divider by the segment width,
// and a final offset/clamp (a zero-width segment skips the divider).
// The back end converts one average at a time and pops the next only
// after the last result has entered the output register; samples can be
// taken while it runs, since a two-entry queue sits between front and back.
// Reset clears the ring (valid bits), running sum, write slot, queue and
// output; levels go to 100/300/600/900. A stalled receiver holds the
// result in the output register; the back end then waits, the queue
// fills, and the front end stops taking any item while a lux item waits
// for room in the queue.
module light_average_to_lux_unit #(
  parameter int RING_SIZE = lal_pkg::RING_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [9:0] reading, [15:10] zero
  input  logic                          in_tuser,   // [0] kind
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] illuminance
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lal_pkg::LVL_W-1:0]     cfg_data
);

  localparam int LW = lal_pkg::LVL_W;

  lal_pkg::cfg_levels_t levels_r;

  // calibration levels; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.l20  <= lal_pkg::LEVEL_20_RST;
      levels_r.l50  <= lal_pkg::LEVEL_50_RST;
      levels_r.l100 <= lal_pkg::LEVEL_100_RST;
      levels_r.l200 <= lal_pkg::LEVEL_200_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lal_pkg::REG_LEVEL_20:  levels_r.l20  <= cfg_data;
        lal_pkg::REG_LEVEL_50:  levels_r.l50  <= cfg_data;
        lal_pkg::REG_LEVEL_100: levels_r.l100 <= cfg_data;
        lal_pkg::REG_LEVEL_200: levels_r.l200 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          push_valid, push_ready;
  logic [LW-1:0] push_avg;
  logic          pop_valid, pop_ready;
  logic [LW-1:0] pop_avg;

  // front: ring, running sum, average
  lal_front #(
    .RING_SIZE (RING_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_reading (in_tdata[LW-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_avg   (push_avg)
  );

  // averages waiting for conversion
  lal_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_avg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_avg)
  );

  // back: segment pick, serial divide, clamp, output register
  lal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .levels    (levels_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_avg   (pop_avg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_illum (out_tdata)
  );

endmodule

// ----- tb/sv/tb_light_average_to_lux_unit.sv -----
module tb_light_average_to_lux_unit;
  import lal_pkg::*;

  // generous bound: ~800 items, plus idle pauses
  localparam int CYCLE_LIMIT = 200000;
  // quiet time after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS = 68;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // every block input starts at a known value
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // [9:0] reading, [15:10] zero
  logic                 in_tuser = 1'b0; // [0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;       // [15:0] illuminance
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LVL_W-1:0]     cfg_data = '0;

  light_average_to_lux_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Expected behavior: own copy of the ring, running sum and levels
  // ---------------------------------------------------------------------------
  cfg_levels_t       levels_model;
  logic [LVL_W-1:0]  ring_model [RING_SIZE_DEF];
  int                slot_model;
  logic [12:0]       sum_model;
  logic [ILL_W-1:0]  lux_expected [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  no_gap_in = 1'b0;     // sender runs back to back
  bit  no_stall_out = 1'b0;  // receiver always ready

  initial begin
    levels_model = '{l20: LEVEL_20_RST, l50: LEVEL_50_RST,
                     l100: LEVEL_100_RST, l200: LEVEL_200_RST};
    foreach (ring_model[i]) ring_model[i] = '0;
    slot_model = 0;
    sum_model = '0;
  end

  // one segment of the calibration curve; truncating signed division
  function automatic longint segment_lux(longint x, longint lo_lvl, longint hi_lvl,
                                         longint lo_lux, longint hi_lux);
    if (hi_lvl == lo_lvl) return hi_lux;  // zero-width segment: upper lux
    return (x - lo_lvl) * (hi_lux - lo_lux) / (hi_lvl - lo_lvl) + lo_lux;
  endfunction

  function automatic logic [ILL_W-1:0] lux_of_average(longint avg);
    longint l20, l50, l100, l200, lux;
    l20  = levels_model.l20;
    l50  = levels_model.l50;
    l100 = levels_model.l100;
    l200 = levels_model.l200;
    // tests in this order even when the levels are not increasing
    if (avg <= l20)       lux = segment_lux(avg, 0, l20, LUX_0, LUX_20);
    else if (avg <= l50)  lux = segment_lux(avg, l20, l50, LUX_20, LUX_50);
    else if (avg <= l100) lux = segment_lux(avg, l50, l100, LUX_50, LUX_100);
    else                  lux = segment_lux(avg, l100, l200, LUX_100, LUX_200);
    if (lux < 0) lux = 0;                  // falling last segment
    if (lux > longint'(ILL_MAX)) lux = longint'(ILL_MAX);
    return lux[ILL_W-1:0];
  endfunction

  // apply one accepted input transfer to the expected state
  function automatic void track_item(bit kind, logic [LVL_W-1:0] reading);
    if (!kind) begin
      sum_model = sum_model - 13'(ring_model[slot_model]) + 13'(reading);
      ring_model[slot_model] = reading;
      slot_model = (slot_model + 1) % RING_SIZE_DEF;
    end else begin
      lux_expected.push_back(lux_of_average(longint'(sum_model) / RING_SIZE_DEF));
    end
  endfunction

  function automatic void note_failure(string msg);
    if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and the check of each transfer
  // ---------------------------------------------------------------------------
  always begin : result_sink
    int stall;
    stall = no_stall_out ? 0 : $urandom_range(0, 3);
    repeat (stall) begin
      out_tready <= 1'b0;
      @(negedge clk);
    end
    out_tready <= 1'b1;
    @(posedge clk);
    while (!(rst_n && out_tvalid === 1'b1 && out_tready)) @(posedge clk);
    @(negedge clk);
  end

  logic [ILL_W-1:0] lux_want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (lux_expected.size() == 0) begin
        note_failure($sformatf("result %0d with nothing outstanding", out_tdata));
      end else begin
        lux_want = lux_expected.pop_front();
        if (out_tdata !== lux_want)
          note_failure($sformatf("illuminance expected %0d, got %0d", lux_want, out_tdata));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL light_average_to_lux_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All entered and left at a falling edge; a valid stays high on
  // return so that a following transfer does not lower and raise it.
  // ---------------------------------------------------------------------------
  task automatic send_item(bit kind, logic [LVL_W-1:0] reading);
    int gap;
    gap = no_gap_in ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, reading};
    do @(posedge clk); while (in_tready !== 1'b1);
    track_item(kind, reading);
    @(negedge clk);
  endtask

  // drop valid, wait for every outstanding result, then let the back end
  // finish anything still in flight
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (lux_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_LEVEL_20:  levels_model.l20  = value;
      REG_LEVEL_50:  levels_model.l50  = value;
      REG_LEVEL_100: levels_model.l100 = value;
      REG_LEVEL_200: levels_model.l200 = value;
      default: ;  // unused index: no effect
    endcase
    @(negedge clk);
  endtask

  task automatic set_levels(int l20, int l50, int l100, int l200);
    wait_drained();
    write_reg(REG_LEVEL_20, l20[LVL_W-1:0]);
    write_reg(REG_LEVEL_50, l50[LVL_W-1:0]);
    write_reg(REG_LEVEL_100, l100[LVL_W-1:0]);
    write_reg(REG_LEVEL_200, l200[LVL_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_ring(int count, logic [LVL_W-1:0] reading);
    repeat (count) send_item(1'b0, reading);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset levels: empty ring averages to zero, then a full ring of the top
  // reading extrapolates past the last breakpoint
  task automatic test_reset_state();
    send_item(1'b1, 10'h3FF);        // reading ignored on a lux item
    fill_ring(RING_SIZE_DEF, 10'h3FF);
    send_item(1'b1, 10'h000);
    fill_ring(2, 10'h155);           // alternating bit patterns
    fill_ring(2, 10'h2AA);
    send_item(1'b1, 10'h2AA);
  endtask

  // corner cases of the calibration curve
  task automatic test_curve_corners();
    fill_ring(4, 10'h3FF);
    // steep last segment: result saturates
    set_levels(0, 0, 0, 1);
    send_item(1'b1, 10'h0);
    // last segment falls below its start: result lies below the segment's start lux
    set_levels(0, 0, 500, 0);
    send_item(1'b1, 10'h0);
    // zero-width last segment
    set_levels(0, 0, 0, 0);
    send_item(1'b1, 10'h0);
    // unused register index changes nothing
    wait_drained();
    write_reg(4'hF, 10'h3FF);
    cfg_valid <= 1'b0;
    send_item(1'b1, 10'h0);
    // all levels at the top: first segment spans the whole range
    set_levels(1023, 1023, 1023, 1023);
    send_item(1'b1, 10'h0);
    fill_ring(4, 10'h000);
    send_item(1'b1, 10'h0);
    // out-of-order levels, then zero-width first segment with a zero average
    set_levels(600, 100, 1023, 0);
    send_item(1'b1, 10'h0);
    fill_ring(4, 10'h000);
    set_levels(0, 0, 300, 900);
    send_item(1'b1, 10'h0);
  endtask

  // phases of random levels and items; readings cluster around a moving
  // center so that averages land in every segment
  task automatic test_random_traffic();
    int lv[$];
    int mode, center, value;
    bit kind;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      lv.delete();
      repeat (4) lv.push_back($urandom_range(0, 1023));
      mode = $urandom_range(0, 5);
      if (mode <= 2) begin
        lv.sort();
      end else if (mode == 4) begin
        lv.sort();
        lv[3] = lv[2] + $urandom_range(0, 3);  // narrow or empty last segment
        if (lv[3] > 1023) lv[3] = 1023;
      end else if (mode == 5) begin
        foreach (lv[i]) lv[i] = $urandom_range(0, 1) ? 1023 : 0;
      end
      set_levels(lv[0], lv[1], lv[2], lv[3]);
      no_gap_in    = ($urandom_range(0, 3) == 0);
      no_stall_out = ($urandom_range(0, 3) == 0);
      center = $urandom_range(0, 1023);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 16 == 0) center = $urandom_range(0, 1023);
        kind = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0) begin
          value = $urandom_range(0, 1023);
        end else begin
          value = center + $urandom_range(0, 128) - 64;
          if (value < 0) value = 0;
          if (value > 1023) value = 1023;
        end
        send_item(kind, value[LVL_W-1:0]);
      end
    end
    no_gap_in    = 1'b0;
    no_stall_out = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_curve_corners();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS light_average_to_lux_unit");
    end else begin
      $display("FAIL light_average_to_lux_unit");
    end
    $finish;
  end

endmodule
